FILE: design/rslb_pkg.sv
// ----------------------------------------------------------------------------
// rslb_pkg
// Shared types, sizes and codes for the resource slot load balancer.
// ----------------------------------------------------------------------------
package rslb_pkg;

    localparam int MaxSlots  = 16;
    localparam int SlotBits  = 4;
    localparam int CoordBits = 8;
    localparam int FracBits  = 16;
    localparam int CountBits = 16;
    localparam int IdBits    = 16;
    localparam int ScoreBits = 40;
    localparam int DistBits  = CoordBits + 2;           // Manhattan plus one, no-neighbor mark
    localparam int NumBits   = CountBits + FracBits;    // dividend width
    localparam int PenBits   = NumBits + SlotBits;      // penalty sum width
    localparam int SqBits    = 2 * CoordBits + 1;       // squared distance

    localparam logic [DistBits-1:0]  NoNeighbor = DistBits'(1) << (CoordBits + 1);
    localparam logic [CountBits-1:0] CountMax   = '1;
    localparam logic [ScoreBits-1:0] ScoreMax   = '1;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_INC  = 2'd1,
        ACT_BEST = 2'd2,
        ACT_NEAR = 2'd3
    } t_action;

    typedef enum logic {
        REG_LOAD_WEIGHT = 1'b0,
        REG_PENALTY_WEIGHT = 1'b1
    } t_reg_index;

    // divider request / response
    typedef struct packed {
        logic                start;
        logic [NumBits-1:0]  num;
        logic [DistBits-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [NumBits-1:0] quo;
    } t_div_rsp;

endpackage

FILE: design/rslb_if.sv
// ----------------------------------------------------------------------------
// rslb_in_if / rslb_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface rslb_in_if;
    import rslb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [3:0]           slot_index;
    logic [15:0]          node_id;
    logic [7:0]           coord_x;
    logic [7:0]           coord_y;
    modport source (output valid, action, slot_index, node_id, coord_x, coord_y,
                    input ready);
    modport sink   (input valid, action, slot_index, node_id, coord_x, coord_y,
                    output ready);
endinterface

interface rslb_out_if;
    logic         valid;
    logic         ready;
    logic         status;
    logic [3:0]   chosen_slot;
    logic [15:0]  chosen_id;
    logic [39:0]  chosen_score;
    modport source (output valid, status, chosen_slot, chosen_id, chosen_score,
                    input ready);
    modport sink   (input valid, status, chosen_slot, chosen_id, chosen_score,
                    output ready);
endinterface

FILE: design/rslb_div.sv
// ----------------------------------------------------------------------------
// rslb_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rslb_div
    import rslb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CntBits = $clog2(NumBits + 1);

    logic [NumBits-1:0]  r_quo, n_quo;
    logic [DistBits:0]   r_rem, n_rem;
    logic [DistBits-1:0] r_den;
    logic [CntBits-1:0]  r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DistBits:0]   w_trial;

    // shift in next dividend bit and try a subtract
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DistBits-1:0], r_quo[NumBits-1]};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_cnt  = CntBits'(NumBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo = {r_quo[NumBits-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[NumBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntBits'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: design/resource_slot_load_balancer_core.sv
// ----------------------------------------------------------------------------
// resource_slot_load_balancer_core
// Slot table with load, increment, nearest and best-score selection.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in channel (action, slot_index, node_id,
// coord_x, coord_y); each accepted beat yields exactly one result beat on the
// out channel (status, chosen_slot, chosen_id, chosen_score). The block takes
// one request at a time: in.ready is high only when idle and no result waits.
// Load and increment pass through the output state to the result. Nearest walks
// the slots one per cycle through one squared-distance unit.
// Best walks the slot pairs of each valid slot; each used pair goes through
// a shared restoring divider, plus a skip or a scoring pass per slot.
// Configuration writes (load_weight index 0, penalty_weight index 1) are to be
// made while idle; the block does not enforce it. Reset clears valid bits and
// counts and sets weights to 1 and 6. A stalled result is held in the output
// register, and no request is accepted until it is taken.
// ----------------------------------------------------------------------------
module resource_slot_load_balancer_core
    import rslb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rslb_in_if.sink     in_ch,
    rslb_out_if.source  out_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_NEAR  = 8'b0000_0010,
        ST_PAIR  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_CMP   = 8'b0010_0000,
        ST_OUT   = 8'b0100_0000,
        ST_ACC   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [3:0] r_lw, r_pw;
    logic [MaxSlots-1:0]  r_valid;
    logic [IdBits-1:0]    r_node [MaxSlots];
    logic [CoordBits-1:0] r_x    [MaxSlots];
    logic [CoordBits-1:0] r_y    [MaxSlots];
    logic [CountBits-1:0] r_cnt  [MaxSlots];

    logic [CoordBits-1:0] r_qx, r_qy;
    logic [SlotBits-1:0]  r_s, r_o;
    logic                 r_found;
    logic [SlotBits-1:0]  r_best;
    logic [SqBits-1:0]    r_bd;
    logic [ScoreBits-1:0] r_bscore;
    logic [DistBits-1:0]  r_bdist;
    logic [PenBits-1:0]   r_pen;
    logic [DistBits-1:0]  r_mind;
    logic [ScoreBits-1:0] r_score;
    logic                 r_ovalid, r_status;
    logic [SlotBits-1:0]  r_oslot;
    logic [IdBits-1:0]    r_oid;
    logic [ScoreBits-1:0] r_oscore;

    t_div_req w_req;
    t_div_rsp w_rsp;

    rslb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // shared distance unit: current slot against query or pair slot
    logic [CoordBits-1:0] w_ax, w_ay, w_bx, w_by, w_dx, w_dy;
    logic [DistBits-1:0]  w_man;
    logic [SqBits-1:0]    w_sq;
    always_comb begin
        w_ax = r_x[r_s];
        w_ay = r_y[r_s];
        w_bx = (r_state == ST_NEAR) ? r_qx : r_x[r_o];
        w_by = (r_state == ST_NEAR) ? r_qy : r_y[r_o];
        w_dx = (w_ax > w_bx) ? w_ax - w_bx : w_bx - w_ax;
        w_dy = (w_ay > w_by) ? w_ay - w_by : w_by - w_ay;
        w_man = DistBits'(w_dx) + DistBits'(w_dy);
        w_sq = SqBits'(w_dx) * SqBits'(w_dx) + SqBits'(w_dy) * SqBits'(w_dy);
    end

    assign w_req.start = (r_state == ST_PAIR) && r_valid[r_o] && (r_o != r_s)
                         && (r_cnt[r_o] != '0);
    assign w_req.num   = {r_cnt[r_o], FracBits'(0)};
    assign w_req.den   = w_man + 1'b1;

    // score terms: combinational products and sum, saturated when registered
    logic [CountBits+3:0]         w_load_prod;
    logic [PenBits+3:0]           w_pen_prod;
    logic [ScoreBits+PenBits-1:0] w_sum;
    assign w_load_prod = r_lw * r_cnt[r_s];
    assign w_pen_prod  = r_pw * r_pen;
    assign w_sum = (ScoreBits + PenBits)'({w_load_prod, FracBits'(0)})
                 + (ScoreBits + PenBits)'(w_pen_prod);

    logic w_take;
    always_comb begin
        priority if (!r_found || r_score < r_bscore) w_take = 1'b1;
        else if (r_score == r_bscore && r_mind > r_bdist) w_take = 1'b1;
        else if (r_score == r_bscore && r_mind == r_bdist
                 && r_node[r_s] < r_node[r_best]) w_take = 1'b1;
        else w_take = 1'b0;
    end

    assign in_ch.ready      = (r_state == ST_IDLE) && !r_ovalid;
    assign out_ch.valid     = r_ovalid;
    assign out_ch.status    = r_status;
    assign out_ch.chosen_slot  = r_oslot;
    assign out_ch.chosen_id    = r_oid;
    assign out_ch.chosen_score = r_oscore;

    logic w_last_s;
    assign w_last_s = (r_s == SlotBits'(MaxSlots - 1));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_lw     <= 4'd1;
            r_pw     <= 4'd6;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MaxSlots; i++) r_cnt[i] <= '0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_LOAD_WEIGHT:    r_lw <= i_cfg_data;
                    REG_PENALTY_WEIGHT: r_pw <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_qx <= in_ch.coord_x;
                        r_qy <= in_ch.coord_y;
                        r_s <= '0;
                        r_o <= '0;
                        r_found <= 1'b0;
                        r_pen <= '0;
                        r_mind <= NoNeighbor;
                        r_oscore <= '0;
                        unique case (t_action'(in_ch.action))
                            ACT_LOAD: begin
                                r_valid[in_ch.slot_index] <= 1'b1;
                                r_node[in_ch.slot_index] <= in_ch.node_id;
                                r_x[in_ch.slot_index] <= in_ch.coord_x;
                                r_y[in_ch.slot_index] <= in_ch.coord_y;
                                r_cnt[in_ch.slot_index] <= '0;
                                r_status <= 1'b0;
                                r_oslot <= in_ch.slot_index;
                                r_oid <= in_ch.node_id;
                                r_state <= ST_OUT;
                            end
                            ACT_INC: begin
                                if (r_cnt[in_ch.slot_index] != CountMax)
                                    r_cnt[in_ch.slot_index] <= r_cnt[in_ch.slot_index] + 1'b1;
                                r_status <= 1'b0;
                                r_oslot <= in_ch.slot_index;
                                r_oid <= '0;
                                r_state <= ST_OUT;
                            end
                            ACT_NEAR: r_state <= ST_NEAR;
                            ACT_BEST: r_state <= ST_PAIR;
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_NEAR: begin
                    if (r_valid[r_s] && (!r_found || w_sq < r_bd)) begin
                        r_found <= 1'b1;
                        r_best <= r_s;
                        r_bd <= w_sq;
                    end
                    r_s <= r_s + 1'b1;
                    if (w_last_s) r_state <= ST_ACC;
                end
                ST_PAIR: begin
                    if (!r_valid[r_s]) begin
                        r_o <= '0;
                        r_s <= r_s + 1'b1;
                        if (w_last_s) r_state <= ST_ACC;
                    end else if (w_req.start) begin
                        if (w_man < r_mind) r_mind <= w_man;
                        r_state <= ST_DIV;
                    end else begin
                        r_o <= r_o + 1'b1;
                        if (r_o == SlotBits'(MaxSlots - 1)) r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (w_rsp.done) begin
                        r_pen <= r_pen + PenBits'(w_rsp.quo);
                        r_o <= r_o + 1'b1;
                        r_state <= (r_o == SlotBits'(MaxSlots - 1)) ? ST_MUL : ST_PAIR;
                    end
                end
                ST_MUL: begin
                    r_score <= (w_sum > (ScoreBits + PenBits)'(ScoreMax))
                               ? ScoreMax : ScoreBits'(w_sum);
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_take) begin
                        r_found <= 1'b1;
                        r_best <= r_s;
                        r_bscore <= r_score;
                        r_bdist <= r_mind;
                    end
                    r_pen <= '0;
                    r_mind <= NoNeighbor;
                    r_o <= '0;
                    r_s <= r_s + 1'b1;
                    r_state <= w_last_s ? ST_ACC : ST_PAIR;
                end
                ST_ACC: begin
                    // finish query, best score only when scoring ran
                    r_status <= !r_found;
                    r_oslot <= r_found ? r_best : '0;
                    r_oid <= r_found ? r_node[r_best] : '0;
                    r_oscore <= r_found ? r_bscore : '0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
            // nearest never sets a best score
            if (r_state == ST_IDLE && in_ch.valid && in_ch.ready) r_bscore <= '0;
        end
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the resource slot load balancer: a predictor of the
// slot table computes each result, a scoreboard compares result beats in order.
// ----------------------------------------------------------------------------
class slot_scoreboard;
    typedef struct packed {
        logic        status;
        logic [3:0]  slot;
        logic [15:0] id;
        logic [39:0] score;
    } t_result;

    t_result     pending[$];
    int          mismatches;
    logic [3:0]  w_load;
    logic [3:0]  w_pen;
    bit          valid_tab[16];
    logic [15:0] node_tab[16];
    logic [7:0]  x_tab[16];
    logic [7:0]  y_tab[16];
    logic [15:0] count_tab[16];

    function void clear();
        w_load = 4'd1;
        w_pen  = 4'd6;
        mismatches = 0;
        pending.delete();
        foreach (valid_tab[i]) begin
            valid_tab[i] = 0;
            count_tab[i] = '0;
            node_tab[i] = '0;
            x_tab[i] = '0;
            y_tab[i] = '0;
        end
    endfunction

    function void set_weight(rslb_pkg::t_reg_index idx, logic [3:0] val);
        if (idx == rslb_pkg::REG_LOAD_WEIGHT) w_load = val;
        else w_pen = val;
    endfunction

    function int unsigned absd(logic [7:0] a, logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // predict the result of one accepted request beat
    function void note_request(logic [1:0] act, logic [3:0] idx, logic [15:0] id,
                               logic [7:0] qx, logic [7:0] qy);
        t_result r;
        bit found;
        int unsigned bsl, m, mind, bdist;
        longint unsigned d, bd, pen, sc, bsc;
        bit take;
        r = '0;
        found = 0;
        bsl = 0; bd = 0; bsc = 0; bdist = 0;
        case (act)
            rslb_pkg::ACT_LOAD: begin
                valid_tab[idx] = 1;
                node_tab[idx] = id;
                x_tab[idx] = qx;
                y_tab[idx] = qy;
                count_tab[idx] = '0;
                r.slot = idx;
                r.id = id;
            end
            rslb_pkg::ACT_INC: begin
                if (count_tab[idx] != 16'hFFFF) count_tab[idx]++;
                r.slot = idx;
            end
            rslb_pkg::ACT_NEAR: begin
                for (int s = 0; s < 16; s++) begin
                    if (!valid_tab[s]) continue;
                    d = absd(x_tab[s], qx) * absd(x_tab[s], qx)
                      + absd(y_tab[s], qy) * absd(y_tab[s], qy);
                    if (!found || d < bd) begin
                        found = 1; bsl = s; bd = d;
                    end
                end
                if (found) begin r.slot = 4'(bsl); r.id = node_tab[bsl]; end
                else r.status = 1;
            end
            default: begin
                for (int s = 0; s < 16; s++) begin
                    if (!valid_tab[s]) continue;
                    pen = 0;
                    mind = 1 << 10;
                    for (int o = 0; o < 16; o++) begin
                        if (o == s || !valid_tab[o] || count_tab[o] == 0) continue;
                        m = absd(x_tab[s], x_tab[o]) + absd(y_tab[s], y_tab[o]);
                        pen += (longint'(count_tab[o]) << 16) / (m + 1);
                        if (m < mind) mind = m;
                    end
                    sc = ((longint'(w_load) * count_tab[s]) << 16) + w_pen * pen;
                    if (sc > 64'hFF_FFFF_FFFF) sc = 64'hFF_FFFF_FFFF;
                    take = !found || sc < bsc
                        || (sc == bsc && mind > bdist)
                        || (sc == bsc && mind == bdist && node_tab[s] < node_tab[bsl]);
                    if (take) begin
                        found = 1; bsl = s; bsc = sc; bdist = mind;
                    end
                end
                if (found) begin
                    r.slot = 4'(bsl); r.id = node_tab[bsl]; r.score = bsc[39:0];
                end else r.status = 1;
            end
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(t_result got);
        t_result exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: result mismatch exp st=%0d slot=%0d id=%0h score=%0h,",
                          " got st=%0d slot=%0d id=%0h score=%0h"},
                         exp_r.status, exp_r.slot, exp_r.id, exp_r.score,
                         got.status, got.slot, got.id, got.score);
        end
    endfunction
endclass

module tb_top;
    import rslb_pkg::*;

    localparam int CycleLimit = 5_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [3:0] i_cfg_data = '0;

    rslb_in_if  in_ch();
    rslb_out_if out_ch();

    resource_slot_load_balancer_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    slot_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;
    longint cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.slot_index = '0;
        in_ch.node_id = '0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        out_ch.ready = 1'b0;
    end

    // long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // result side: random stall, hold-off on request, check each beat
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result({out_ch.status, out_ch.chosen_slot, out_ch.chosen_id,
                                out_ch.chosen_score});
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (cycles > CycleLimit) begin
            $display("resource_slot_load_balancer_core verification failed");
            $finish;
        end
    end

    // drive one request beat, idling at random beforehand
    task automatic send_req(t_action act, logic [3:0] idx, logic [15:0] id,
                            logic [7:0] qx, logic [7:0] qy);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.slot_index <= idx;
        in_ch.node_id <= id;
        in_ch.coord_x <= qx;
        in_ch.coord_y <= qy;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_request(act, idx, id, qx, qy);
        in_ch.valid <= 1'b0;
        // block is busy for the next cycle anyway
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [3:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_weight(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random beat; indices mostly 0 to 7, keeping the slot count small
    task automatic random_req();
        t_action act;
        logic [3:0] idx;
        act = t_action'($urandom_range(3));
        idx = 4'($urandom_range(7));
        if ($urandom_range(9) == 0) idx = 4'($urandom_range(15));
        send_req(act, idx, 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        board.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, ties
        send_req(ACT_BEST, 4'd0, 16'h0, 8'h0, 8'h0);
        send_req(ACT_NEAR, 4'd0, 16'h0, 8'hFF, 8'hFF);
        send_req(ACT_INC, 4'd15, 16'hFFFF, 8'hFF, 8'hFF);
        send_req(ACT_LOAD, 4'd15, 16'hFFFF, 8'hFF, 8'hFF);
        send_req(ACT_LOAD, 4'd0, 16'h0000, 8'h00, 8'h00);
        send_req(ACT_LOAD, 4'd5, 16'h1234, 8'h00, 8'h00);
        send_req(ACT_NEAR, 4'd0, 16'h0, 8'h00, 8'h00);
        send_req(ACT_NEAR, 4'd0, 16'h0, 8'hFF, 8'hFF);
        send_req(ACT_BEST, 4'd0, 16'h0, 8'h0, 8'h0);
        send_req(ACT_INC, 4'd0, 16'h0, 8'h0, 8'h0);
        send_req(ACT_INC, 4'd15, 16'h0, 8'h0, 8'h0);
        send_req(ACT_BEST, 4'd0, 16'h0, 8'h0, 8'h0);
        send_req(ACT_LOAD, 4'd10, 16'hA5A5, 8'h80, 8'h7F);
        send_req(ACT_NEAR, 4'd0, 16'h0, 8'h80, 8'h80);
        send_req(ACT_BEST, 4'd0, 16'h0, 8'h0, 8'h0);
        drain();

        // heaviest weights on a few used slots
        write_reg(REG_LOAD_WEIGHT, 4'd15);
        write_reg(REG_PENALTY_WEIGHT, 4'd15);
        for (int i = 0; i < 5; i++) send_req(ACT_INC, 4'd15, 16'h0, 8'h0, 8'h0);
        send_req(ACT_BEST, 4'd0, 16'h0, 8'h0, 8'h0);
        drain();

        // random phases with different idling and weights
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_reg(REG_LOAD_WEIGHT, (ph == 1) ? 4'd0 : 4'($urandom_range(15)));
            write_reg(REG_PENALTY_WEIGHT, (ph == 2) ? 4'd0 : 4'($urandom_range(15)));
            if (ph == 4) hold_cycles = 3000;
            for (int n = 0; n < 18; n++) random_req();
            drain();
        end

        drain();
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("resource_slot_load_balancer_core verification clean");
        else
            $display("resource_slot_load_balancer_core verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
design/rslb_pkg.sv
design/rslb_if.sv
design/rslb_div.sv
design/resource_slot_load_balancer_core.sv
bench/tb_top.sv
